// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- sv/pemc_pkg.sv -----
// ----------------------------------------------------------------------------
// pemc_pkg
// types and constants of the palette expander with mean color
// ----------------------------------------------------------------------------
`default_nettype none

package pemc_pkg;

  localparam int PaletteEntries = 256;
  localparam int MaxPixels      = 1048576;

  localparam int ByteW   = 8;
  localparam int ByteMax = (2 ** ByteW) - 1;
  localparam int NumCh   = 3;
  localparam int EntryW  = NumCh * ByteW;
  localparam int SlotW   = 8;
  localparam int WordW   = 32;
  localparam int FmtW    = 2;
  localparam int SumW    = 28;
  localparam int CountW  = 21;
  localparam int MeanW   = 16;
  localparam int FracW   = MeanW - ByteW;
  localparam int AddrW   = $clog2(PaletteEntries);

  // one quotient bit per divider step
  localparam int DivSteps = MeanW;
  localparam int StepW    = $clog2(DivSteps);

  typedef enum logic [FmtW-1:0] {
    FMT_INDEXED   = 2'd0,
    FMT_FOUR_BYTE = 2'd1,
    FMT_PASS      = 2'd2
  } fmt_e;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_PIXEL     = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             opcode;
    logic [SlotW-1:0] palette_slot;
    logic [ByteW-1:0] entry_byte_zero;
    logic [ByteW-1:0] entry_byte_one;
    logic [ByteW-1:0] entry_byte_two;
    logic [WordW-1:0] pixel_word;
    logic             last_pixel;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte_zero;
    logic [ByteW-1:0] out_byte_one;
    logic [ByteW-1:0] out_byte_two;
    logic [MeanW-1:0] mean_red;
    logic [MeanW-1:0] mean_green;
    logic [MeanW-1:0] mean_blue;
    logic             means_valid;
    logic             last_out;
  } out_t;

  typedef struct packed {
    logic accept;
    logic pal_write;
    logic lookup;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic need_div;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- sv/pemc_ram.sv -----
// ----------------------------------------------------------------------------
// pemc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pemc_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/pemc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pemc_ctrl
// sequencer: word intake, palette lookup, divider steps and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module pemc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire pemc_pkg::ctrl_sts_t   sts_i,
  output pemc_pkg::ctrl_cmd_t        cmd_o
);

  pemc_pkg::state_e state_q, state_d;
  logic [pemc_pkg::StepW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pemc_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      pemc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_write) begin
            cmd_o.pal_write = 1'b1;
          end else begin
            state_d = pemc_pkg::ST_LOOKUP;
          end
        end
      end
      pemc_pkg::ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        step_d       = '0;
        if (sts_i.need_div) begin
          state_d = pemc_pkg::ST_DIVIDE;
        end else begin
          state_d = pemc_pkg::ST_EMIT;
        end
      end
      pemc_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        step_d         = pemc_pkg::StepW'(step_q + 1'b1);
        if (step_q == pemc_pkg::StepW'(pemc_pkg::DivSteps - 1)) begin
          state_d = pemc_pkg::ST_EMIT;
        end
      end
      pemc_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = pemc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pemc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/pemc_dp.sv -----
// ----------------------------------------------------------------------------
// pemc_dp
// datapath: palette ram, byte reorder, channel sums, mean divider, output reg
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pemc_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [pemc_pkg::FmtW-1:0]   cfg_wdata_i,
  input  wire pemc_pkg::in_t               in_i,
  input  wire pemc_pkg::ctrl_cmd_t         cmd_i,
  output pemc_pkg::ctrl_sts_t              sts_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output pemc_pkg::out_t                   out_o
);

  logic [pemc_pkg::FmtW-1:0]   fmt_q;
  logic                        indexed;

  logic                        ram_we;
  logic                        ram_re;
  logic [pemc_pkg::EntryW-1:0] ram_wdata;
  logic [pemc_pkg::EntryW-1:0] ram_rdata;

  logic [pemc_pkg::WordW-1:0]  word_q;
  logic                        last_q;
  logic                        hit_q;

  logic [pemc_pkg::EntryW-1:0] entry;
  logic [pemc_pkg::ByteW-1:0]  chan      [pemc_pkg::NumCh];
  logic                        acc_en;
  logic [pemc_pkg::SumW-1:0]   sum_q     [pemc_pkg::NumCh];
  logic [pemc_pkg::SumW-1:0]   sum_upd   [pemc_pkg::NumCh];
  logic [pemc_pkg::CountW-1:0] count_q;
  logic [pemc_pkg::CountW-1:0] count_upd;
  pemc_pkg::out_t              res_d, res_q;

  logic [pemc_pkg::CountW-1:0] div_q;
  logic [pemc_pkg::CountW-1:0] rem_q     [pemc_pkg::NumCh];
  logic [pemc_pkg::CountW-1:0] rem_d     [pemc_pkg::NumCh];
  logic [pemc_pkg::MeanW-1:0]  quo_q     [pemc_pkg::NumCh];
  logic [pemc_pkg::CountW:0]   trial     [pemc_pkg::NumCh];
  logic                        ge        [pemc_pkg::NumCh];
  logic [pemc_pkg::MeanW-1:0]  mean_fin  [pemc_pkg::NumCh];

  logic                        out_valid_q;
  pemc_pkg::out_t              out_d, out_q;

  assign indexed = (fmt_q == pemc_pkg::FMT_INDEXED);

  // palette store
  assign ram_we    = cmd_i.pal_write &&
                     (int'(in_i.palette_slot) < pemc_pkg::PaletteEntries);
  assign ram_re    = cmd_i.accept && (in_i.opcode == pemc_pkg::OP_PIXEL);
  assign ram_wdata = {in_i.entry_byte_two, in_i.entry_byte_one, in_i.entry_byte_zero};

  pemc_ram #(
    .Width (pemc_pkg::EntryW),
    .Depth (pemc_pkg::PaletteEntries)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.palette_slot[pemc_pkg::AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_i.pixel_word[pemc_pkg::AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // lookup, reorder and accumulate
  always_comb begin
    entry  = hit_q ? ram_rdata : '0;
    acc_en = indexed && (int'(count_q) < pemc_pkg::MaxPixels);
    for (int k = 0; k < pemc_pkg::NumCh; k++) begin
      chan[k]    = entry[k*pemc_pkg::ByteW +: pemc_pkg::ByteW];
      sum_upd[k] = acc_en ? pemc_pkg::SumW'(sum_q[k] + pemc_pkg::SumW'(chan[k]))
                          : sum_q[k];
    end
    count_upd = acc_en ? pemc_pkg::CountW'(count_q + 1'b1) : count_q;

    res_d          = '0;
    res_d.last_out = last_q;
    if (indexed) begin
      res_d.out_byte_zero = chan[2];
      res_d.out_byte_one  = chan[1];
      res_d.out_byte_two  = chan[0];
      res_d.means_valid   = last_q;
    end else begin
      res_d.out_byte_zero = word_q[0*pemc_pkg::ByteW +: pemc_pkg::ByteW];
      res_d.out_byte_one  = word_q[1*pemc_pkg::ByteW +: pemc_pkg::ByteW];
      res_d.out_byte_two  = word_q[2*pemc_pkg::ByteW +: pemc_pkg::ByteW];
    end
  end

  // restoring divider, three lanes sharing one divisor
  always_comb begin
    for (int k = 0; k < pemc_pkg::NumCh; k++) begin
      trial[k]    = {rem_q[k], quo_q[k][pemc_pkg::MeanW-1]};
      ge[k]       = (trial[k] >= {1'b0, div_q});
      rem_d[k]    = ge[k] ? pemc_pkg::CountW'(trial[k] - {1'b0, div_q})
                          : pemc_pkg::CountW'(trial[k]);
      mean_fin[k] = (res_q.means_valid && (div_q != '0)) ? quo_q[k] : '0;
    end
  end

  always_comb begin
    out_d            = res_q;
    out_d.mean_red   = mean_fin[0];
    out_d.mean_green = mean_fin[1];
    out_d.mean_blue  = mean_fin[2];
  end

  assign sts_o.is_write = (in_i.opcode == pemc_pkg::OP_PAL_WRITE);
  assign sts_o.need_div = indexed && last_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // control state and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= pemc_pkg::FmtW'(pemc_pkg::FMT_INDEXED);
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < pemc_pkg::NumCh; k++) begin
        sum_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      if (cmd_i.lookup) begin
        count_q <= last_q ? '0 : count_upd;
        for (int k = 0; k < pemc_pkg::NumCh; k++) begin
          sum_q[k] <= last_q ? '0 : sum_upd[k];
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      word_q <= in_i.pixel_word;
      last_q <= in_i.last_pixel;
      hit_q  <= int'(in_i.pixel_word[pemc_pkg::ByteW-1:0]) < pemc_pkg::PaletteEntries;
    end
    if (cmd_i.lookup) begin
      res_q <= res_d;
      if (indexed && last_q) begin
        div_q <= count_upd;
        for (int k = 0; k < pemc_pkg::NumCh; k++) begin
          rem_q[k] <= pemc_pkg::CountW'(sum_upd[k] >> pemc_pkg::FracW);
          quo_q[k] <= {sum_upd[k][pemc_pkg::FracW-1:0],
                       {(pemc_pkg::MeanW-pemc_pkg::FracW){1'b0}}};
        end
      end
    end
    if (cmd_i.div_step) begin
      for (int k = 0; k < pemc_pkg::NumCh; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= {quo_q[k][pemc_pkg::MeanW-2:0], ge[k]};
      end
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `ASSERT_NEVER(count_limit_a, clk_i, rst_ni,
                int'(count_q) > pemc_pkg::MaxPixels, "pixel count over limit")
  `ASSERT_PROP(sum_bound_a, clk_i, rst_ni,
               int'(sum_q[0]) <= pemc_pkg::ByteMax * int'(count_q),
               "red sum exceeds count bound")
  `ASSERT_PROP(rem_bound_a, clk_i, rst_ni, cmd_i.div_step |-> (rem_q[0] < div_q),
               "divider remainder not below divisor")
  `ASSERT_PROP(means_last_a, clk_i, rst_ni,
               (out_valid_q && out_q.means_valid) |-> out_q.last_out,
               "means without last pixel")

endmodule

`default_nettype wire

// ----- sv/palette_expand_with_mean_color.sv -----
// ----------------------------------------------------------------------------
// palette_expand_with_mean_color
// indexed, four-byte or passthrough pixel expansion to 24-bit color, with
// per-channel 8.8 mean color reported on the last indexed pixel
// ----------------------------------------------------------------------------
//  channel   dir   handshake               payload
//  cfg       in    cfg_we_i                cfg_wdata_i (source format)
//  in        in    in_valid_i / in_ready_o in_i  (pemc_pkg::in_t)
//  out       out   out_valid_o/out_ready_i out_o (pemc_pkg::out_t)
//
//  palette write: written on accept; pixel: accept, palette read, hand-off
//  last indexed pixel: also passes through the 16-step bit-serial divider
//  reset clears format, sums, count and output valid; palette ram is not reset
//  the output register holds a result under stall while the next word is taken;
//  a second result then waits in the hand-off state until the register frees
// ----------------------------------------------------------------------------
`default_nettype none

module palette_expand_with_mean_color (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [pemc_pkg::FmtW-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire pemc_pkg::in_t             in_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output pemc_pkg::out_t                 out_o
);

  pemc_pkg::ctrl_cmd_t cmd;
  pemc_pkg::ctrl_sts_t sts;

  pemc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pemc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// directed table then random textures, checked against an in-order predictor
// random stalls on both sides and one long receiver hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int ResetCycles  = 12;
  localparam int SettleCycles = 32;
  localparam int TailCycles   = 40;
  localparam int SqueezeLen   = 400;
  localparam int StallLimit   = 5000;
  localparam logic [pemc_pkg::FmtW-1:0] FmtSpare = 2'd3;

  typedef struct {
    bit             pinned;
    pemc_pkg::out_t val;
  } pin_t;

  typedef struct {
    logic [pemc_pkg::FmtW-1:0] fmt;
    pemc_pkg::in_t             w;
    bit                        pinned;
    pemc_pkg::out_t            val;
  } stim_row_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [pemc_pkg::FmtW-1:0] cfg_wdata = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  pemc_pkg::in_t             in_word   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  pemc_pkg::out_t            out_word;

  palette_expand_with_mean_color dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
  end

  // predicted state of the block
  logic [pemc_pkg::EntryW-1:0] palette_mem [pemc_pkg::PaletteEntries];
  logic [pemc_pkg::SumW-1:0]   sum_red, sum_green, sum_blue;
  logic [pemc_pkg::CountW-1:0] px_count;
  logic [pemc_pkg::FmtW-1:0]   model_fmt;

  pemc_pkg::out_t color_q[$];
  pin_t           pinned_q[$];

  int                         fails       = 0;
  int                         sent_items  = 0;
  int                         tx_idle_pct = 0;
  int                         rx_idle_pct = 0;
  bit                         squeeze_req = 1'b0;
  bit                         squeeze_on  = 1'b0;
  logic [pemc_pkg::FmtW-1:0]  cur_fmt     = pemc_pkg::FMT_INDEXED;
  bit                         slot_used [pemc_pkg::PaletteEntries];
  logic [pemc_pkg::SlotW-1:0] written_slots[$];
  stim_row_t                  stim_rows[$];
  int                         quiet = 0;

  initial begin
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    px_count  = '0;
    model_fmt = pemc_pkg::FMT_INDEXED;
  end

  function automatic logic [pemc_pkg::MeanW-1:0] mean_8p8(
      logic [pemc_pkg::SumW-1:0] s, logic [pemc_pkg::CountW-1:0] n);
    logic [63:0] q;
    if (n == 0) return '0;
    q = ({36'd0, s} << pemc_pkg::FracW) / n;
    return q[pemc_pkg::MeanW-1:0];
  endfunction

  task automatic expand_word(input pemc_pkg::in_t w, input pin_t pin);
    pemc_pkg::out_t             r;
    logic [pemc_pkg::ByteW-1:0] b0, b1, b2;
    r = '0;
    if (w.opcode == pemc_pkg::OP_PAL_WRITE) begin
      if (w.palette_slot < pemc_pkg::PaletteEntries)
        palette_mem[w.palette_slot] = {w.entry_byte_two, w.entry_byte_one,
                                       w.entry_byte_zero};
    end else begin
      r.last_out = w.last_pixel;
      if (model_fmt == pemc_pkg::FMT_INDEXED) begin
        {b2, b1, b0} = palette_mem[w.pixel_word[7:0]];
        r.out_byte_zero = b2;
        r.out_byte_one  = b1;
        r.out_byte_two  = b0;
        if (px_count < pemc_pkg::MaxPixels) begin
          sum_red   = sum_red + b0;
          sum_green = sum_green + b1;
          sum_blue  = sum_blue + b2;
          px_count  = px_count + 1'b1;
        end
        if (w.last_pixel) begin
          r.mean_red    = mean_8p8(sum_red, px_count);
          r.mean_green  = mean_8p8(sum_green, px_count);
          r.mean_blue   = mean_8p8(sum_blue, px_count);
          r.means_valid = 1'b1;
        end
      end else begin
        r.out_byte_zero = w.pixel_word[7:0];
        r.out_byte_one  = w.pixel_word[15:8];
        r.out_byte_two  = w.pixel_word[23:16];
      end
      if (w.last_pixel) begin
        sum_red   = '0;
        sum_green = '0;
        sum_blue  = '0;
        px_count  = '0;
      end
      color_q.push_back(pin.pinned ? pin.val : r);
    end
  endtask

  function automatic void check_field(string name, logic [pemc_pkg::MeanW-1:0] exp_v,
                                      logic [pemc_pkg::MeanW-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    pin_t           p;
    pemc_pkg::out_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (color_q.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          e = color_q.pop_front();
          check_field("out_byte_zero", pemc_pkg::MeanW'(e.out_byte_zero),
                      pemc_pkg::MeanW'(out_word.out_byte_zero));
          check_field("out_byte_one", pemc_pkg::MeanW'(e.out_byte_one),
                      pemc_pkg::MeanW'(out_word.out_byte_one));
          check_field("out_byte_two", pemc_pkg::MeanW'(e.out_byte_two),
                      pemc_pkg::MeanW'(out_word.out_byte_two));
          check_field("mean_red", e.mean_red, out_word.mean_red);
          check_field("mean_green", e.mean_green, out_word.mean_green);
          check_field("mean_blue", e.mean_blue, out_word.mean_blue);
          check_field("means_valid", pemc_pkg::MeanW'(e.means_valid),
                      pemc_pkg::MeanW'(out_word.means_valid));
          check_field("last_out", pemc_pkg::MeanW'(e.last_out),
                      pemc_pkg::MeanW'(out_word.last_out));
        end
      end
      if (cfg_we) model_fmt = cfg_wdata;
      if (in_valid && in_ready) begin
        p = pinned_q.pop_front();
        expand_word(in_word, p);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == StallLimit) begin
      $display("FAIL palette_expand_with_mean_color");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        squeeze_on  = 1'b1;
        out_ready <= 1'b0;
        repeat (SqueezeLen) @(posedge clk);
        squeeze_on  = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_word(input pemc_pkg::in_t w, input bit pinned,
                           input pemc_pkg::out_t val);
    pin_t p;
    p.pinned = pinned;
    p.val    = val;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pinned_q.push_back(p);
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.opcode == pemc_pkg::OP_PAL_WRITE && !slot_used[w.palette_slot]) begin
      slot_used[w.palette_slot] = 1'b1;
      written_slots.push_back(w.palette_slot);
    end
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (color_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_format(input logic [pemc_pkg::FmtW-1:0] f);
    drain();
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_fmt = f;
  endtask

  function automatic void pal_row(logic [pemc_pkg::FmtW-1:0] f,
                                  logic [pemc_pkg::SlotW-1:0] slot,
                                  logic [pemc_pkg::ByteW-1:0] b0,
                                  logic [pemc_pkg::ByteW-1:0] b1,
                                  logic [pemc_pkg::ByteW-1:0] b2);
    stim_row_t r;
    r.fmt                   = f;
    r.w                     = '0;
    r.w.opcode              = pemc_pkg::OP_PAL_WRITE;
    r.w.palette_slot        = slot;
    r.w.entry_byte_zero     = b0;
    r.w.entry_byte_one      = b1;
    r.w.entry_byte_two      = b2;
    r.pinned                = 1'b0;
    r.val                   = '0;
    stim_rows.push_back(r);
  endfunction

  function automatic void px_row(logic [pemc_pkg::FmtW-1:0] f,
                                 logic [pemc_pkg::WordW-1:0] word, logic last,
                                 bit pinned, pemc_pkg::out_t val);
    stim_row_t r;
    r.fmt          = f;
    r.w            = '0;
    r.w.opcode     = pemc_pkg::OP_PIXEL;
    r.w.pixel_word = word;
    r.w.last_pixel = last;
    r.pinned       = pinned;
    r.val          = val;
    stim_rows.push_back(r);
  endfunction

  task automatic random_texture();
    pemc_pkg::in_t w;
    int            n_wr;
    int            n_px;
    n_wr = (written_slots.size() == 0) ? 4 : $urandom_range(0, 6);
    n_px = ($urandom_range(9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
    repeat (n_wr) begin
      w                 = pemc_pkg::in_t'({$urandom, $urandom, $urandom});
      w.opcode          = pemc_pkg::OP_PAL_WRITE;
      send_word(w, 1'b0, '0);
    end
    for (int i = 0; i < n_px; i++) begin
      w = pemc_pkg::in_t'({$urandom, $urandom, $urandom});
      if ($urandom_range(9) == 0) begin
        w.opcode = pemc_pkg::OP_PAL_WRITE;
      end else begin
        w.opcode = pemc_pkg::OP_PIXEL;
        if (cur_fmt == pemc_pkg::FMT_INDEXED)
          w.pixel_word[7:0] = written_slots[$urandom_range(written_slots.size() - 1)];
        // stray last words break some textures early
        w.last_pixel = (i == n_px - 1) || ($urandom_range(39) == 0);
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int tx, input int rx, input int upto, input bit squeeze);
    int f;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    if (squeeze) squeeze_req = 1'b1;
    while (sent_items < upto) begin
      // keep offering words while the receiver holds off
      if (!squeeze_req && !squeeze_on && ($urandom_range(3) == 0)) begin
        f = $urandom_range(0, 5);
        set_format((f > 3) ? pemc_pkg::FMT_INDEXED : f[pemc_pkg::FmtW-1:0]);
      end
      random_texture();
    end
  endtask

  initial begin
    pal_row(pemc_pkg::FMT_INDEXED, 8'h00, 8'h00, 8'h00, 8'h00);
    pal_row(pemc_pkg::FMT_INDEXED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    pal_row(pemc_pkg::FMT_INDEXED, 8'h01, 8'h12, 8'h34, 8'h56);
    pal_row(pemc_pkg::FMT_INDEXED, 8'hAA, 8'h5A, 8'hA5, 8'h3C);
    px_row(pemc_pkg::FMT_INDEXED, 32'h0000_0000, 1'b0, 1'b1,
           {8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0});
    px_row(pemc_pkg::FMT_INDEXED, 32'hFFFF_FFFF, 1'b1, 1'b1,
           {8'hFF, 8'hFF, 8'hFF, 16'h7F80, 16'h7F80, 16'h7F80, 1'b1, 1'b1});
    px_row(pemc_pkg::FMT_INDEXED, 32'hABCD_EF01, 1'b1, 1'b1,
           {8'h56, 8'h34, 8'h12, 16'h1200, 16'h3400, 16'h5600, 1'b1, 1'b1});
    px_row(pemc_pkg::FMT_INDEXED, 32'h0000_00FF, 1'b0, 1'b1,
           {8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0});
    px_row(pemc_pkg::FMT_INDEXED, 32'h1234_56FF, 1'b1, 1'b1,
           {8'hFF, 8'hFF, 8'hFF, 16'hFF00, 16'hFF00, 16'hFF00, 1'b1, 1'b1});
    px_row(pemc_pkg::FMT_INDEXED, 32'h5555_55AA, 1'b0, 1'b0, '0);
    px_row(pemc_pkg::FMT_INDEXED, 32'hAAAA_AA01, 1'b0, 1'b0, '0);
    px_row(pemc_pkg::FMT_INDEXED, 32'h0000_00FF, 1'b0, 1'b0, '0);
    // last word in another format still clears the sums
    px_row(pemc_pkg::FMT_FOUR_BYTE, 32'hFFFF_FFFF, 1'b1, 1'b1,
           {8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1});
    px_row(pemc_pkg::FMT_INDEXED, 32'h0000_00FF, 1'b1, 1'b1,
           {8'hFF, 8'hFF, 8'hFF, 16'hFF00, 16'hFF00, 16'hFF00, 1'b1, 1'b1});
    px_row(pemc_pkg::FMT_FOUR_BYTE, 32'hDEAD_BEEF, 1'b0, 1'b1,
           {8'hEF, 8'hBE, 8'hAD, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0});
    px_row(pemc_pkg::FMT_PASS, 32'h0000_0000, 1'b0, 1'b1,
           {8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0});
    px_row(pemc_pkg::FMT_PASS, 32'hFFFF_FFFF, 1'b1, 1'b1,
           {8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1});
    px_row(FmtSpare, 32'h80FF_0001, 1'b0, 1'b1,
           {8'h01, 8'h00, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0});
    pal_row(FmtSpare, 8'h55, 8'h01, 8'h02, 8'h03);
    pal_row(pemc_pkg::FMT_INDEXED, 8'h7F, 8'h80, 8'h7F, 8'h01);
    px_row(pemc_pkg::FMT_INDEXED, 32'h0000_0055, 1'b0, 1'b0, '0);
    px_row(pemc_pkg::FMT_INDEXED, 32'h0000_007F, 1'b1, 1'b0, '0);

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    tx_idle_pct = 18;
    rx_idle_pct = 64;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].fmt != cur_fmt) set_format(stim_rows[i].fmt);
      send_word(stim_rows[i].w, stim_rows[i].pinned, stim_rows[i].val);
    end

    run_phase(18, 64, 570, 1'b0);
    run_phase(64, 18, 1110, 1'b0);
    run_phase(0, 0, 1650, 1'b1);

    drain();
    repeat (TailCycles) @(posedge clk);
    if (fails == 0) begin
      $display("PASS palette_expand_with_mean_color");
    end else begin
      $display("FAIL palette_expand_with_mean_color");
    end
    $finish;
  end

endmodule

`default_nettype wire
